/* design/spsm_pkg.sv */
// shared types, widths and status codes of the streaming pair sum matcher
// no dependencies
`default_nettype none

package spsm_pkg;

    localparam int SPSM_MAX_LEN = 1024;
    localparam int VALUE_W      = 32;
    localparam int IDX_W        = 10;
    localparam int STATUS_W     = 2;
    localparam int EPOCH_W      = 8;

    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PAIR    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

    // one slot of the hash table; live only while tag equals the current epoch
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [VALUE_W-1:0] key;
        logic [IDX_W-1:0]   pos;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    cur_idx;
        logic [IDX_W-1:0]    partner_idx;
    } res_t;

endpackage

`default_nettype wire

/* design/spsm_table.sv */
// hash table storage: one write port, one read port with registered data
// depends on spsm_pkg
`default_nettype none

module spsm_table
    import spsm_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data
);

    entry_t store_mem [2**ADDR_W];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/spsm_ctrl.sv */
// sequencer: epoch clearing, linear-probe lookup of the partner and of the value, insert
// depends on spsm_pkg, drives spsm_table
`default_nettype none

module spsm_ctrl
    import spsm_pkg::*;
#(
    parameter int MAX_LEN = SPSM_MAX_LEN,
    parameter int ADDR_W  = $clog2(SPSM_MAX_LEN) + 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [VALUE_W-1:0] target,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] in_value,
    input  wire logic               in_first,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output res_t                    res,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    input  wire entry_t             rd_data,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output entry_t                  wr_data
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int TW    = ADDR_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // xor fold of a key onto the table address
    function automatic logic [TW-1:0] fold(input logic [VALUE_W-1:0] k);
        logic [TW-1:0] h;
        h = '0;
        for (int i = 0; i < VALUE_W; i++) begin
            h[i % TW] = h[i % TW] ^ k[i];
        end
        return h;
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               match_reg, match_next;
    logic [EPOCH_W-1:0] ep_reg, ep_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               pend_reg, pend_next;
    logic               phase_reg, phase_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    res_t               res_reg, res_next;

    logic [CNT_W+IDX_W-1:0] idx_wide;
    logic [IDX_W-1:0]       idx10;
    logic [VALUE_W:0]       need;
    logic                   live;
    logic                   same;

    assign idx_wide = {{IDX_W{1'b0}}, cnt_reg};
    assign idx10    = idx_wide[IDX_W-1:0];
    assign need     = {target[VALUE_W-1], target} - {val_reg[VALUE_W-1], val_reg};
    assign live     = (rd_data.tag == ep_reg);
    assign same     = live && (rd_data.key == key_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        cnt_next      = cnt_reg;
        match_next    = match_reg;
        ep_next       = ep_reg;
        clr_addr_next = clr_addr_reg;
        pend_next     = pend_reg;
        phase_next    = phase_reg;
        key_next      = key_reg;
        addr_next     = addr_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;
        wr_en         = 1'b0;
        wr_addr       = clr_addr_reg;
        wr_data       = '0;

        case (state_reg)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                    ep_next    = EPOCH_W'(1);
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_START : S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    val_next   = in_value;
                    state_next = S_START;
                    if (in_first) begin
                        cnt_next   = '0;
                        match_next = 1'b0;
                        // tags run out: sweep the table, then carry on with this item
                        if (ep_reg == {EPOCH_W{1'b1}}) begin
                            pend_next     = 1'b1;
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end else begin
                            ep_next = ep_reg + 1'b1;
                        end
                    end
                end
            end
            S_START: begin
                if (match_reg) begin
                    res_next   = '{status: ST_IGNORED, cur_idx: idx10, partner_idx: '0};
                    state_next = S_OUT;
                end else if (cnt_reg >= CNT_W'(MAX_LEN)) begin
                    res_next   = '{status: ST_OVER, cur_idx: '0, partner_idx: '0};
                    state_next = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_PROBE;
                    // a partner outside the 32-bit range cannot be stored
                    if (need[VALUE_W] == need[VALUE_W-1]) begin
                        key_next   = need[VALUE_W-1:0];
                        phase_next = 1'b0;
                    end else begin
                        key_next   = val_reg;
                        phase_next = 1'b1;
                    end
                    addr_next = fold(key_next);
                    rd_addr   = addr_next;
                end
            end
            S_PROBE: begin
                if (same) begin
                    if (!phase_reg) begin
                        res_next   = '{status: ST_PAIR, cur_idx: idx10,
                                       partner_idx: rd_data.pos};
                        match_next = 1'b1;
                    end else begin
                        res_next = '{status: ST_MISS, cur_idx: idx10, partner_idx: '0};
                    end
                    state_next = S_OUT;
                end else if (!live) begin
                    if (!phase_reg) begin
                        // partner absent, now look for the value itself
                        phase_next = 1'b1;
                        key_next   = val_reg;
                        addr_next  = fold(val_reg);
                        rd_en      = 1'b1;
                        rd_addr    = addr_next;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = addr_reg;
                        wr_data    = '{tag: ep_reg, key: val_reg, pos: idx10};
                        res_next   = '{status: ST_MISS, cur_idx: idx10, partner_idx: '0};
                        state_next = S_OUT;
                    end
                end else begin
                    addr_next = addr_reg + 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = addr_next;
                end
            end
            S_OUT: begin
                if (res_ready) begin
                    if (cnt_reg < CNT_W'(MAX_LEN)) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            match_reg    <= 1'b0;
            ep_reg       <= '0;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            match_reg    <= match_next;
            ep_reg       <= ep_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        phase_reg <= phase_next;
        key_reg   <= key_next;
        addr_reg  <= addr_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

/* design/streaming_pair_sum_matcher.sv */
// from input transfer to m_tvalid: start state, a probe state per table probe, result state,
// output register; a looked-up item uses one or more probes for its partner (none if it lies
// outside the 32-bit range) and, on a miss, more for its value; a new item is taken only once
// the last result has gone to the output register; reset: a sweep over all 2*MAX_LEN slots
// (rounded up to a power of two) clears the tags; the same sweep runs again with the item held
// after every 255th first-flagged array; reset also sets target_sum to 0 and starts an array
`default_nettype none

module streaming_pair_sum_matcher
    import spsm_pkg::*;
#(
    parameter int MAX_LEN = SPSM_MAX_LEN
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,   // target_sum
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // value
    input  wire logic [0:0]  s_tuser,     // first
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // current_index, partner_index, zero pad
    output logic [1:0]       m_tuser      // status
);

    localparam int ADDR_W = $clog2(MAX_LEN) + 1;

    logic [VALUE_W-1:0] target_reg;
    logic               m_valid_reg, m_valid_next;
    res_t               out_reg;
    res_t               res;
    logic               res_valid;
    logic               res_ready;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    entry_t             rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_we) begin
            target_reg <= cfg_wdata;
        end
    end

    // output register lets the sequencer move on while a result waits
    assign res_ready    = !m_valid_reg || m_tready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'd0, out_reg.partner_idx, out_reg.cur_idx};

    spsm_ctrl #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .target    (target_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_first  (s_tuser[0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    spsm_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire
